/* hw/rtl/iadmp_pkg.sv */
// iadmp_pkg: shared constants and types for the integer alu core
// no dependencies
package iadmp_pkg;

	localparam int DATA_WIDTH_DEF = 64;
	localparam int CMD_W = 4;
	localparam int KIND_W = 2;

	localparam logic [CMD_W-1:0] CMD_ADD   = 4'd0;
	localparam logic [CMD_W-1:0] CMD_SUB   = 4'd1;
	localparam logic [CMD_W-1:0] CMD_NEG   = 4'd2;
	localparam logic [CMD_W-1:0] CMD_MUL   = 4'd3;
	localparam logic [CMD_W-1:0] CMD_DIV   = 4'd4;
	localparam logic [CMD_W-1:0] CMD_RECIP = 4'd5;
	localparam logic [CMD_W-1:0] CMD_REM   = 4'd6;
	localparam logic [CMD_W-1:0] CMD_MOD   = 4'd7;
	localparam logic [CMD_W-1:0] CMD_POW   = 4'd8;
	localparam logic [CMD_W-1:0] CMD_LT    = 4'd9;
	localparam logic [CMD_W-1:0] CMD_GT    = 4'd10;
	localparam logic [CMD_W-1:0] CMD_EQ    = 4'd11;
	localparam logic [CMD_W-1:0] CMD_NE    = 4'd12;
	localparam logic [CMD_W-1:0] CMD_ZERO  = 4'd13;
	localparam logic [CMD_W-1:0] CMD_ONE   = 4'd14;
	localparam logic [CMD_W-1:0] CMD_UNIT  = 4'd15;

	localparam logic [KIND_W-1:0] KIND_INT  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_PINF = 2'd1;
	localparam logic [KIND_W-1:0] KIND_NINF = 2'd2;
	localparam logic [KIND_W-1:0] KIND_NAN  = 2'd3;

	// unit operations
	localparam logic [1:0] UOP_DIV = 2'd0;
	localparam logic [1:0] UOP_MUL = 2'd1;
	localparam logic [1:0] UOP_POW = 2'd2;

	typedef struct packed {
		logic       start;
		logic [1:0] op;
	} iadmp_req_t;

endpackage

/* hw/rtl/integer_alu_div_mod_pow_core.sv */
// integer_alu_div_mod_pow_core: top level of the signed integer alu
// depends on iadmp_pkg and iadmp_seq_unit
//
// channel | dir | handshake         | payload
// s_axis  | in  | tvalid/tready     | tdata: cmd[3:0], operand_a[67:4], operand_b[131:68]
// m_axis  | out | tvalid/tready     | tdata: value[63:0], kind[65:64], overflow[66]
//
// simple ops are computed in the sequencer itself; div/rem/mod, mul and pow
// all run in the one shared shift/add unit. reset clears control only. the
// input is not ready until the result word is taken, a stalled output holds
// its word.
module integer_alu_div_mod_pow_core
	import iadmp_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [135:0] s_axis_tdata,  // cmd, operand_a, operand_b
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [71:0]  m_axis_tdata   // value, kind, overflow
);

	localparam int W = DATA_WIDTH;
	localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0]     st_q;
	logic [CMD_W-1:0] cmd_q;
	logic [W-1:0]   a_q, b_q;
	logic           wait_q;
	logic [W-1:0]   val_q;
	logic [KIND_W-1:0] kind_q;
	logic           ovf_q;

	iadmp_req_t     req;
	logic [W-1:0]   ua, ub, u_lo, u_hi;
	logic           u_done;

	logic           na, nb, sn;
	logic [W-1:0]   ma, mb;
	logic [W:0]     sum;

	assign na = a_q[W-1];
	assign nb = b_q[W-1];
	assign sn = na ^ nb;
	assign ma = na ? -a_q : a_q;
	assign mb = nb ? -b_q : b_q;

	assign s_axis_tready = (st_q == ST_IDLE);
	assign m_axis_tvalid = (st_q == ST_OUT);
	assign m_axis_tdata  = {5'd0, ovf_q, kind_q, {{(64-W){val_q[W-1]}}, val_q}};

	iadmp_seq_unit #(.W(W)) u_seq (
		.clk(clk), .arst_n(arst_n), .req(req), .opa(ua), .opb(ub),
		.done(u_done), .res_lo(u_lo), .res_hi(u_hi)
	);

	// unit request
	always_comb begin
		req.start = 1'b0;
		req.op    = UOP_DIV;
		ua        = ma;
		ub        = mb;
		if (st_q == ST_RUN) begin
			unique case (cmd_q)
				CMD_MUL: begin
					req.start = 1'b1;
					req.op    = UOP_MUL;
				end
				CMD_DIV, CMD_REM, CMD_MOD: req.start = (b_q != '0);
				CMD_POW: begin
					req.start = !nb;
					req.op    = UOP_POW;
					ua        = a_q;
					ub        = b_q;
				end
				default: req.start = 1'b0;
			endcase
		end
	end

	// shared adder for add/sub/neg
	always_comb begin
		unique case (cmd_q)
			CMD_SUB: sum = {a_q[W-1], a_q} - {b_q[W-1], b_q};
			CMD_NEG: sum = '0 - {a_q[W-1], a_q};
			default: sum = {a_q[W-1], a_q} + {b_q[W-1], b_q};
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			wait_q <= 1'b0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						cmd_q <= s_axis_tdata[3:0];
						a_q   <= s_axis_tdata[4 +: W];
						b_q   <= s_axis_tdata[68 +: W];
						st_q  <= ST_RUN;
					end
				end
				ST_RUN: begin
					wait_q <= req.start;
					st_q   <= ST_FIN;
					val_q  <= '0;
					kind_q <= KIND_INT;
					ovf_q  <= 1'b0;
					unique case (cmd_q)
						CMD_ADD, CMD_SUB, CMD_NEG: begin
							val_q <= sum[W-1:0];
							ovf_q <= sum[W] ^ sum[W-1];
						end
						CMD_DIV: if (b_q == '0) begin
							kind_q <= (a_q == '0) ? KIND_NAN : (na ? KIND_NINF : KIND_PINF);
						end
						CMD_RECIP: begin
							if (a_q == '0) kind_q <= KIND_PINF;
							else if (a_q == W'(1) || a_q == '1) val_q <= a_q;
						end
						CMD_POW: if (nb) begin
							if (a_q == W'(1)) val_q <= W'(1);
							else if (a_q == '1) val_q <= b_q[0] ? '1 : W'(1);
						end
						CMD_LT:   val_q <= W'($signed(a_q) < $signed(b_q));
						CMD_GT:   val_q <= W'($signed(b_q) < $signed(a_q));
						CMD_EQ:   val_q <= W'(a_q == b_q);
						CMD_NE:   val_q <= W'(a_q != b_q);
						CMD_ZERO: val_q <= W'(a_q == '0);
						CMD_ONE:  val_q <= W'(a_q == W'(1));
						CMD_UNIT: val_q <= W'(a_q == W'(1) || a_q == '1);
						default: ;
					endcase
				end
				ST_FIN: begin
					if (!wait_q) begin
						st_q <= ST_OUT;
					end else if (u_done) begin
						wait_q <= 1'b0;
						st_q   <= ST_OUT;
						unique case (cmd_q)
							CMD_MUL: begin
								val_q <= sn ? -u_lo : u_lo;
								ovf_q <= (u_hi != '0) ||
									(sn ? (u_lo > WMIN) : u_lo[W-1]);
							end
							CMD_DIV: begin
								val_q <= sn ? -u_lo : u_lo;
								ovf_q <= !sn && u_lo[W-1];
							end
							CMD_REM: val_q <= na ? -u_hi : u_hi;
							CMD_MOD: begin
								if (u_hi != '0 && na != nb)
									val_q <= (na ? -u_hi : u_hi) + b_q;
								else
									val_q <= na ? -u_hi : u_hi;
							end
							default: val_q <= u_lo;
						endcase
					end
				end
				default: begin
					if (m_axis_tready) st_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* hw/rtl/iadmp_seq_unit.sv */
// iadmp_seq_unit: shared shift/add unit stepped one bit per cycle
// serves restoring division, shift-add multiply and square-and-multiply power
// depends on iadmp_pkg
module iadmp_seq_unit
	import iadmp_pkg::*;
#(
	parameter int W = DATA_WIDTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  iadmp_req_t   req,
	input  logic [W-1:0] opa,     // dividend / multiplicand / base magnitude or raw
	input  logic [W-1:0] opb,     // divisor / multiplier / exponent
	output logic         done,
	output logic [W-1:0] res_lo,  // quotient / low product / power
	output logic [W-1:0] res_hi   // remainder / high product
);

	localparam int CW = $clog2(W + 1);

	// power phases: multiply acc*x then square x
	localparam logic [1:0] PH_STEP = 2'd0;
	localparam logic [1:0] PH_MACC = 2'd1;
	localparam logic [1:0] PH_MSQR = 2'd2;

	logic [1:0]   op_q;
	logic         busy_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0] a_q, b_q, hi_q, lo_q;
	// power state
	logic [W-1:0] acc_q, x_q, y_q;
	logic [1:0]   ph_q;
	logic [CW-1:0] mcnt_q;
	logic [W-1:0] mm_q, mr_q, mp_q;

	logic [W:0]   trial;
	logic [W:0]   addv;

	assign res_lo = (op_q == UOP_POW) ? acc_q : lo_q;
	assign res_hi = hi_q;

	// trial subtract for division and partial-sum add for multiply
	always_comb begin
		trial = {hi_q[W-1:0], lo_q[W-1]} - {1'b0, b_q};
		addv  = {1'b0, hi_q} + {1'b0, (lo_q[0] ? a_q : '0)};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			op_q   <= UOP_DIV;
			cnt_q  <= '0;
			ph_q   <= PH_STEP;
			mcnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
				cnt_q  <= CW'(W);
				a_q    <= opa;
				b_q    <= opb;
				hi_q   <= '0;
				lo_q   <= (req.op == UOP_DIV) ? opa : opb;
				acc_q  <= W'(1);
				x_q    <= opa;
				y_q    <= opb;
				ph_q   <= PH_STEP;
			end else if (busy_q) begin
				unique case (op_q)
					UOP_DIV: begin
						// restoring division, one quotient bit per cycle
						if (!trial[W]) begin
							hi_q <= trial[W-1:0];
							lo_q <= {lo_q[W-2:0], 1'b1};
						end else begin
							hi_q <= {hi_q[W-2:0], lo_q[W-1]};
							lo_q <= {lo_q[W-2:0], 1'b0};
						end
						cnt_q <= cnt_q - 1'b1;
						if (cnt_q == CW'(1)) begin
							busy_q <= 1'b0;
							done   <= 1'b1;
						end
					end
					UOP_MUL: begin
						// shift-add multiply, product in hi:lo
						hi_q  <= addv[W:1];
						lo_q  <= {addv[0], lo_q[W-1:1]};
						cnt_q <= cnt_q - 1'b1;
						if (cnt_q == CW'(1)) begin
							busy_q <= 1'b0;
							done   <= 1'b1;
						end
					end
					default: begin
						// square and multiply, low-half products by shift-add
						unique case (ph_q)
							PH_STEP: begin
								if (y_q == '0) begin
									busy_q <= 1'b0;
									done   <= 1'b1;
								end else begin
									mm_q   <= y_q[0] ? acc_q : x_q;
									mr_q   <= x_q;
									mp_q   <= '0;
									mcnt_q <= CW'(W);
									ph_q   <= y_q[0] ? PH_MACC : PH_MSQR;
								end
							end
							default: begin
								mp_q   <= mp_q + (mr_q[0] ? mm_q : '0);
								mm_q   <= {mm_q[W-2:0], 1'b0};
								mr_q   <= {1'b0, mr_q[W-1:1]};
								mcnt_q <= mcnt_q - 1'b1;
								if (mcnt_q == CW'(1)) begin
									if (ph_q == PH_MACC) begin
										acc_q  <= mp_q + (mr_q[0] ? mm_q : '0);
										mm_q   <= x_q;
										mr_q   <= x_q;
										mp_q   <= '0;
										mcnt_q <= CW'(W);
										ph_q   <= PH_MSQR;
									end else begin
										x_q  <= mp_q + (mr_q[0] ? mm_q : '0);
										y_q  <= {1'b0, y_q[W-1:1]};
										ph_q <= PH_STEP;
									end
								end
							end
						endcase
					end
				endcase
			end
		end
	end

endmodule

/* hw/rtl/iadmp_checker.sv */
// iadmp_checker: port-level checks for the integer alu core
// depends on iadmp_pkg; bound to integer_alu_div_mod_pow_core
module iadmp_checker
	import iadmp_pkg::*;
(
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [71:0]  m_axis_tdata
);

	// one word in flight: never ready while a result is shown
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid)) else $error("ready with result pending");

	// accept drops ready next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("ready after accept");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed under stall");

	// non-integer kind carries zero value and no overflow
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[65:64] != KIND_INT |->
		m_axis_tdata[63:0] == 64'd0 && !m_axis_tdata[66]) else $error("bad special kind");

endmodule

bind integer_alu_div_mod_pow_core iadmp_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
